// ----- src/chb_pkg.sv -----
// Shared types, constants and helpers for the chunked body decoder.
`timescale 1ns / 1ps

package chb_pkg;

    // Width of the running byte totals; the reported counts saturate to 32 bits.
    localparam int COUNT_BITS     = 32;
    localparam int OUT_COUNT_BITS = 32;
    localparam int CMP_BITS       = ((COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS
                                                                   : OUT_COUNT_BITS) + 1;

    localparam int SIZE_BITS = 32;
    localparam logic [SIZE_BITS-1:0] SIZE_LIMIT = 32'h0fff_ffff;

    localparam logic [7:0] CHAR_CR   = 8'h0d;
    localparam logic [7:0] CHAR_LF   = 8'h0a;
    localparam logic [7:0] CHAR_SEMI = 8'h3b;

    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CAP_LIMIT  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CAP_ENABLE = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // One classified input byte.
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       is_cr;
        logic       is_lf;
        logic       is_semi;
        logic       is_hex;
        logic [3:0] hex_val;
    } byte_item_t;

    // Saturate a running total to the reported count width.
    function automatic logic [OUT_COUNT_BITS-1:0] sat_out(input logic [COUNT_BITS-1:0] v);
        logic [CMP_BITS-1:0] w;
        w = CMP_BITS'(v);
        if (w > CMP_BITS'({OUT_COUNT_BITS{1'b1}})) begin
            return '1;
        end
        return w[OUT_COUNT_BITS-1:0];
    endfunction

endpackage

// ----- src/http_chunked_body_decoder.sv -----
// Top level of the HTTP/1.1 chunked transfer body decoder.
`timescale 1ns / 1ps

// Decodes a chunked body fed one byte per request on the s_ stream (tuser
// high marks the first byte of a new body and restarts decoding). Each
// payload byte comes out as a BYTE result as it arrives; the consumer must
// discard already delivered bytes if an ERROR result follows. After the
// zero-size chunk and the trailer section a single DONE result carries the
// decoded and consumed byte counts (saturating). Bare LF, CR without LF,
// missing or non-hex size digits, oversize chunk sizes and, when enabled,
// capacity overruns give one ERROR result; after DONE or ERROR the block
// drops bytes silently until the next body start. Throughput is one byte
// per clock while m_tready does not stall the output: the front classifier
// pushes into a two-entry queue and the back state machine retires one
// queued byte per cycle, writing any result into the output register.
// Configuration writes (cfg_index 0: capacity limit, 1: capacity check
// enable) are always accepted and should only be issued between bodies.

module http_chunked_body_decoder
    import chb_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,

    // input byte stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] body_byte
    input  logic                      s_tuser,   // [0] body_start

    // result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [71:0]               m_tdata,   // [7:0] payload_byte,
                                                 // [39:8] decoded_count,
                                                 // [71:40] consumed_count
    output logic [1:0]                m_tuser,   // [1:0] result_kind

    // configuration writes
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0]               cfg_data
);

    byte_item_t front_item;
    byte_item_t q_item;
    logic       q_valid;
    logic       q_pop;

    logic [31:0] cap_limit_reg;
    logic        cap_enable_reg;

    kind_t                     res_kind;
    logic [7:0]                res_payload;
    logic [OUT_COUNT_BITS-1:0] res_decoded;
    logic [OUT_COUNT_BITS-1:0] res_consumed;

    // config registers; writes never stall
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_limit_reg  <= '1;
            cap_enable_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_CAP_LIMIT:  cap_limit_reg  <= cfg_data;
                REG_CAP_ENABLE: cap_enable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // front: byte classification
    chb_front u_front (
        .body_byte  (s_tdata),
        .body_start (s_tuser),
        .item       (front_item)
    );

    // decoupling queue
    chb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (front_item),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_item  (q_item)
    );

    // back: framing state machine and result register
    chb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .cap_limit  (cap_limit_reg),
        .cap_enable (cap_enable_reg),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_kind     (res_kind),
        .m_payload  (res_payload),
        .m_decoded  (res_decoded),
        .m_consumed (res_consumed)
    );

    assign m_tdata = {res_consumed, res_decoded, res_payload};
    assign m_tuser = res_kind;

`ifndef SYNTHESIS
    // payload never outruns total bytes consumed
    a_dec_le_cons: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[39:8] <= m_tdata[71:40]))
        else $error("decoded count exceeds consumed count");

    // non-byte results carry a zero payload
    a_payload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_BYTE) |-> (m_tdata[7:0] == 8'h00))
        else $error("payload set on a non-byte result");

    // a payload byte always counts itself
    a_byte_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_BYTE) |-> (m_tdata[39:8] != 32'd0))
        else $error("byte result with zero decoded count");
`endif

endmodule

// ----- src/chb_front.sv -----
// Front end: classifies each incoming body byte.
`timescale 1ns / 1ps

module chb_front
    import chb_pkg::*;
(
    input  logic [7:0] body_byte,
    input  logic       body_start,
    output byte_item_t item
);

    logic is_dec;
    logic is_lower;
    logic is_upper;

    always_comb begin
        is_dec   = (body_byte >= 8'h30) && (body_byte <= 8'h39);
        is_lower = (body_byte >= 8'h61) && (body_byte <= 8'h66);
        is_upper = (body_byte >= 8'h41) && (body_byte <= 8'h46);

        item.data    = body_byte;
        item.start   = body_start;
        item.is_cr   = (body_byte == CHAR_CR);
        item.is_lf   = (body_byte == CHAR_LF);
        item.is_semi = (body_byte == CHAR_SEMI);
        item.is_hex  = is_dec || is_lower || is_upper;
        // letters a-f / A-F have low nibble 1..6, value is that plus 9
        item.hex_val = is_dec ? body_byte[3:0] : (body_byte[3:0] + 4'd9);
    end

endmodule

// ----- src/chb_queue.sv -----
// Short queue of classified bytes between front and back.
`timescale 1ns / 1ps

module chb_queue
    import chb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  byte_item_t in_item,
    output logic       out_valid,
    input  logic       out_pop,
    output byte_item_t out_item
);

    byte_item_t entry_reg [QUEUE_DEPTH];

    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic                 push;
    logic                 pop;

    always_comb begin
        in_ready  = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
        out_valid = (count_reg != '0);
        out_item  = entry_reg[rd_ptr_reg];
        push      = in_valid && in_ready;
        pop       = out_pop && out_valid;

        wr_ptr_next = wr_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        rd_ptr_next = rd_ptr_reg;
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QCNT_BITS'(push) - QCNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- src/chb_back.sv -----
// Back end: chunk framing state machine, counters and output register.
`timescale 1ns / 1ps

module chb_back
    import chb_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    input  byte_item_t                q_item,
    output logic                      q_pop,
    input  logic [31:0]               cap_limit,
    input  logic                      cap_enable,
    output logic                      m_valid,
    input  logic                      m_ready,
    output kind_t                     m_kind,
    output logic [7:0]                m_payload,
    output logic [OUT_COUNT_BITS-1:0] m_decoded,
    output logic [OUT_COUNT_BITS-1:0] m_consumed
);

    typedef enum logic [9:0] {
        PH_SIZE     = 10'b00_0000_0001,
        PH_EXT      = 10'b00_0000_0010,
        PH_SIZE_LF  = 10'b00_0000_0100,
        PH_DATA     = 10'b00_0000_1000,
        PH_DATA_CR  = 10'b00_0001_0000,
        PH_DATA_LF  = 10'b00_0010_0000,
        PH_TRAILER  = 10'b00_0100_0000,
        PH_TRAIL_LF = 10'b00_1000_0000,
        PH_DONE     = 10'b01_0000_0000,
        PH_ERROR    = 10'b10_0000_0000
    } phase_t;

    phase_t                phase_reg, phase_next, phase_e;
    logic [SIZE_BITS-1:0]  rem_reg, rem_next, rem_e;
    logic                  seen_reg, seen_next, seen_e;
    logic                  tle_reg, tle_next, tle_e;
    logic [COUNT_BITS-1:0] dec_reg, dec_next, dec_e, dec_inc;
    logic [COUNT_BITS-1:0] cons_reg, cons_next, cons_e, cons_inc;

    logic                  m_valid_reg;
    kind_t                 kind_reg;
    logic [7:0]            payload_reg;
    logic [OUT_COUNT_BITS-1:0] decoded_reg, consumed_reg;

    logic                  emit;
    logic                  fail;
    kind_t                 emit_kind;
    logic [7:0]            emit_byte;
    logic                  cap_fail;
    logic [CMP_BITS-1:0]   dec_x, lim_x, rem_x;

    always_comb begin
        q_pop = q_valid && (!m_valid_reg || m_ready);

        // body start restarts before the byte is looked at
        phase_e = q_item.start ? PH_SIZE : phase_reg;
        rem_e   = q_item.start ? '0      : rem_reg;
        seen_e  = q_item.start ? 1'b0    : seen_reg;
        tle_e   = q_item.start ? 1'b1    : tle_reg;
        dec_e   = q_item.start ? '0      : dec_reg;
        cons_e  = q_item.start ? '0      : cons_reg;

        dec_inc  = (dec_e != '1)  ? dec_e + 1'b1  : dec_e;
        cons_inc = (cons_e != '1) ? cons_e + 1'b1 : cons_e;

        dec_x    = CMP_BITS'(dec_e);
        lim_x    = CMP_BITS'(cap_limit);
        rem_x    = CMP_BITS'(rem_e);
        cap_fail = (dec_x > lim_x) || (rem_x > lim_x - dec_x);

        phase_next = phase_reg;
        rem_next   = rem_reg;
        seen_next  = seen_reg;
        tle_next   = tle_reg;
        dec_next   = dec_reg;
        cons_next  = cons_reg;
        emit       = 1'b0;
        fail       = 1'b0;
        emit_kind  = KIND_BYTE;
        emit_byte  = '0;

        if (q_pop) begin
            phase_next = phase_e;
            rem_next   = rem_e;
            seen_next  = seen_e;
            tle_next   = tle_e;
            dec_next   = dec_e;
            cons_next  = cons_e;

            if (phase_e != PH_DONE && phase_e != PH_ERROR) begin
                cons_next = cons_inc;
                unique case (phase_e)
                    PH_SIZE: begin
                        if (q_item.is_cr) begin
                            if (!seen_e) fail = 1'b1;
                            else         phase_next = PH_SIZE_LF;
                        end else if (q_item.is_semi) begin
                            if (!seen_e) fail = 1'b1;
                            else         phase_next = PH_EXT;
                        end else if (!q_item.is_hex || rem_e > SIZE_LIMIT) begin
                            fail = 1'b1;
                        end else begin
                            rem_next  = {rem_e[SIZE_BITS-5:0], q_item.hex_val};
                            seen_next = 1'b1;
                        end
                    end
                    PH_EXT: begin
                        if (q_item.is_lf)      fail = 1'b1;
                        else if (q_item.is_cr) phase_next = PH_SIZE_LF;
                    end
                    PH_SIZE_LF: begin
                        if (!q_item.is_lf) begin
                            fail = 1'b1;
                        end else if (rem_e == '0) begin
                            tle_next   = 1'b1;
                            phase_next = PH_TRAILER;
                        end else if (cap_enable && cap_fail) begin
                            fail = 1'b1;
                        end else begin
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        dec_next  = dec_inc;
                        rem_next  = rem_e - 1'b1;
                        if (rem_e == SIZE_BITS'(1)) phase_next = PH_DATA_CR;
                        emit      = 1'b1;
                        emit_kind = KIND_BYTE;
                        emit_byte = q_item.data;
                    end
                    PH_DATA_CR: begin
                        if (!q_item.is_cr) fail = 1'b1;
                        else               phase_next = PH_DATA_LF;
                    end
                    PH_DATA_LF: begin
                        if (!q_item.is_lf) begin
                            fail = 1'b1;
                        end else begin
                            rem_next   = '0;
                            seen_next  = 1'b0;
                            phase_next = PH_SIZE;
                        end
                    end
                    PH_TRAILER: begin
                        if (q_item.is_lf)      fail = 1'b1;
                        else if (q_item.is_cr) phase_next = PH_TRAIL_LF;
                        else                   tle_next = 1'b0;
                    end
                    PH_TRAIL_LF: begin
                        if (!q_item.is_lf) begin
                            fail = 1'b1;
                        end else if (tle_e) begin
                            phase_next = PH_DONE;
                            emit       = 1'b1;
                            emit_kind  = KIND_DONE;
                        end else begin
                            tle_next   = 1'b1;
                            phase_next = PH_TRAILER;
                        end
                    end
                    default: fail = 1'b1;
                endcase

                if (fail) begin
                    phase_next = PH_ERROR;
                    emit       = 1'b1;
                    emit_kind  = KIND_ERROR;
                    emit_byte  = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SIZE;
            rem_reg     <= '0;
            seen_reg    <= 1'b0;
            tle_reg     <= 1'b1;
            dec_reg     <= '0;
            cons_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            seen_reg  <= seen_next;
            tle_reg   <= tle_next;
            dec_reg   <= dec_next;
            cons_reg  <= cons_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            kind_reg     <= emit_kind;
            payload_reg  <= emit_byte;
            decoded_reg  <= sat_out(dec_next);
            consumed_reg <= sat_out(cons_next);
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_kind     = kind_reg;
    assign m_payload  = payload_reg;
    assign m_decoded  = decoded_reg;
    assign m_consumed = consumed_reg;

endmodule
